// ===== rtl/negative_base_converter_unit_macros.svh =====
// ----------------------------------------------------------------------------
// Negative base converter assertion macros
// Shared concurrent assertion forms, clocked on clk_i and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef NEGATIVE_BASE_CONVERTER_UNIT_MACROS_SVH
`define NEGATIVE_BASE_CONVERTER_UNIT_MACROS_SVH

// Same-cycle implication
`define NBC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define NBC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/nbc_pkg.sv =====
// ----------------------------------------------------------------------------
// Negative base converter package
// Widths, character constants and small helper functions.
// ----------------------------------------------------------------------------
package nbc_pkg;

  // Field widths
  localparam int VALUE_WIDTH = 32;
  localparam int RADIX_WIDTH = 7;
  localparam int CHAR_WIDTH  = 7;
  localparam int BASE_WIDTH  = 6;
  localparam int MAX_DIGITS  = 33;

  // Digit store and divider step counter
  localparam int ADDR_W = $clog2(MAX_DIGITS);
  localparam int STEP_W = $clog2(VALUE_WIDTH);
  localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(VALUE_WIDTH - 1);

  // Base limits
  localparam logic [BASE_WIDTH-1:0] BASE_MIN = BASE_WIDTH'(2);
  localparam logic [BASE_WIDTH-1:0] BASE_MAX = BASE_WIDTH'(36);

  // ASCII offsets: '0' + m, and 'A' - 10 + m
  localparam logic [CHAR_WIDTH-1:0] CHAR_ZERO  = CHAR_WIDTH'(48);
  localparam logic [CHAR_WIDTH-1:0] CHAR_ALPHA = CHAR_WIDTH'(55);
  localparam logic [BASE_WIDTH-1:0] DEC_LIMIT  = BASE_WIDTH'(10);

  // Configuration register addresses
  localparam logic [0:0] ADDR_RADIX = 1'b0;

  // Positive base from the radix register, clamped to 2..36
  function automatic logic [BASE_WIDTH-1:0] radix_base(input logic signed [RADIX_WIDTH-1:0] r);
    logic [BASE_WIDTH-1:0] b;
    if (r > -2) begin
      b = BASE_MIN;
    end else if (r < -36) begin
      b = BASE_MAX;
    end else begin
      b = BASE_WIDTH'(-r);
    end
    return b;
  endfunction

  // Digit value to ASCII character
  function automatic logic [CHAR_WIDTH-1:0] digit_to_char(input logic [BASE_WIDTH-1:0] m);
    logic [CHAR_WIDTH-1:0] c;
    if (m < DEC_LIMIT) begin
      c = CHAR_ZERO + CHAR_WIDTH'(m);
    end else begin
      c = CHAR_ALPHA + CHAR_WIDTH'(m);
    end
    return c;
  endfunction

endpackage

// ===== rtl/nbc_ram.sv =====
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module nbc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/negative_base_converter_unit.sv =====
// ----------------------------------------------------------------------------
// Negative base converter unit
// Converts a signed integer to digits of a negative radix (-2 .. -36),
// emitted as ASCII characters, most significant first, with a last flag.
// ----------------------------------------------------------------------------
//
//   channel  | signals                          | transfer when
//   ---------+----------------------------------+-------------------------
//   input    | value_i                          | in_valid_i & !in_stall_o
//   output   | digit_char_o, last_digit_o       | out_valid_o & !out_stall_i
//   config   | psel/penable/pwrite/paddr/pwdata | psel & penable & pwrite
//
// Each digit of an item takes 32 steps of the shared one-bit restoring
// divider plus one digit write; the digits are then read back from the digit
// RAM one at a time (read, load, send states) and presented, plus stall time.
// Only one item is in flight; in_stall_o is high from accept to last digit.
// Reset sets the radix register to -2 and the sequencer to idle.
// ----------------------------------------------------------------------------
module negative_base_converter_unit
  import nbc_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // Input channel
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  logic [VALUE_WIDTH-1:0] value_i,
  // Output channel
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output logic [CHAR_WIDTH-1:0]  digit_char_o,
  output logic                   last_digit_o,
  // Configuration port
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [0:0]             paddr,
  input  logic [31:0]            pwdata,
  output logic [31:0]            prdata,
  output logic                   pready
);

  // Sequencer states
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_DIV  = 3'd1;
  localparam logic [2:0] S_FIX  = 3'd2;
  localparam logic [2:0] S_READ = 3'd3;
  localparam logic [2:0] S_LOAD = 3'd4;
  localparam logic [2:0] S_SEND = 3'd5;

  logic [2:0]             state_q, state_d;
  logic [STEP_W-1:0]      step_q, step_d;
  logic [ADDR_W-1:0]      cnt_q, cnt_d;
  logic [ADDR_W-1:0]      idx_q, idx_d;
  logic [RADIX_WIDTH-1:0] radix_q;

  logic [VALUE_WIDTH-1:0] quo_q, quo_d;
  logic [BASE_WIDTH-1:0]  prem_q, prem_d;
  logic                   neg_q, neg_d;
  logic [CHAR_WIDTH-1:0]  char_q, char_d;
  logic                   last_q, last_d;

  logic [BASE_WIDTH-1:0]  base;
  logic [BASE_WIDTH:0]    shifted;
  logic [BASE_WIDTH:0]    diff;
  logic                   ge;
  logic [BASE_WIDTH-1:0]  rem;
  logic [VALUE_WIDTH-1:0] mag_next;
  logic [VALUE_WIDTH-1:0] in_mag;

  logic                   ram_we;
  logic                   ram_re;
  logic [CHAR_WIDTH-1:0]  ram_rdata;

  // Configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radix_q <= RADIX_WIDTH'(-2);
    end else if (psel && penable && pwrite && (paddr == ADDR_RADIX)) begin
      radix_q <= pwdata[RADIX_WIDTH-1:0];
    end
  end

  assign prdata = (paddr == ADDR_RADIX) ? 32'(radix_q) : 32'd0;
  assign pready = 1'b1;

  assign base = radix_base(radix_q);

  // Shared divider step: one quotient bit per cycle
  assign shifted = {prem_q, quo_q[VALUE_WIDTH-1]};
  assign diff    = shifted - {1'b0, base};
  assign ge      = (shifted >= {1'b0, base});

  // Digit and next magnitude from the finished unsigned division
  always_comb begin
    if (neg_q && (prem_q != '0)) begin
      rem      = base - prem_q;
      mag_next = quo_q + VALUE_WIDTH'(1);
    end else begin
      rem      = prem_q;
      mag_next = quo_q;
    end
  end

  assign in_mag = value_i[VALUE_WIDTH-1] ? (~value_i + VALUE_WIDTH'(1)) : value_i;

  // Sequencer
  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    cnt_d   = cnt_q;
    idx_d   = idx_q;
    quo_d   = quo_q;
    prem_d  = prem_q;
    neg_d   = neg_q;
    char_d  = char_q;
    last_d  = last_q;
    ram_we  = 1'b0;
    ram_re  = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          quo_d   = in_mag;
          neg_d   = value_i[VALUE_WIDTH-1];
          prem_d  = '0;
          step_d  = '0;
          cnt_d   = '0;
          state_d = S_DIV;
        end
      end
      S_DIV: begin
        prem_d = ge ? diff[BASE_WIDTH-1:0] : shifted[BASE_WIDTH-1:0];
        quo_d  = {quo_q[VALUE_WIDTH-2:0], ge};
        step_d = step_q + STEP_W'(1);
        if (step_q == STEP_LAST) begin
          state_d = S_FIX;
        end
      end
      S_FIX: begin
        ram_we = 1'b1;
        quo_d  = mag_next;
        prem_d = '0;
        step_d = '0;
        neg_d  = !neg_q;
        if ((mag_next == '0) || (cnt_q == ADDR_W'(MAX_DIGITS - 1))) begin
          idx_d   = cnt_q;
          state_d = S_READ;
        end else begin
          cnt_d   = cnt_q + ADDR_W'(1);
          state_d = S_DIV;
        end
      end
      S_READ: begin
        ram_re  = 1'b1;
        state_d = S_LOAD;
      end
      S_LOAD: begin
        char_d  = ram_rdata;
        last_d  = (idx_q == '0);
        state_d = S_SEND;
      end
      S_SEND: begin
        if (!out_stall_i) begin
          if (idx_q == '0) begin
            state_d = S_IDLE;
          end else begin
            idx_d   = idx_q - ADDR_W'(1);
            state_d = S_READ;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      step_q  <= '0;
      cnt_q   <= '0;
      idx_q   <= '0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
      cnt_q   <= cnt_d;
      idx_q   <= idx_d;
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    quo_q  <= quo_d;
    prem_q <= prem_d;
    neg_q  <= neg_d;
    char_q <= char_d;
    last_q <= last_d;
  end

  // Digit store, written least significant first, read back in reverse
  nbc_ram #(
    .WIDTH (CHAR_WIDTH),
    .DEPTH (MAX_DIGITS)
  ) u_digit_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (cnt_q),
    .wdata_i (digit_to_char(rem)),
    .re_i    (ram_re),
    .raddr_i (idx_q),
    .rdata_o (ram_rdata)
  );

  assign in_stall_o   = (state_q != S_IDLE);
  assign out_valid_o  = (state_q == S_SEND);
  assign digit_char_o = char_q;
  assign last_digit_o = last_q;

endmodule

// ===== rtl/nbc_checker.sv =====
// ----------------------------------------------------------------------------
// Negative base converter checker
// Port-level assertions, bound to the top level.
// ----------------------------------------------------------------------------
`include "negative_base_converter_unit_macros.svh"

module nbc_checker
  import nbc_pkg::*;
(
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  in_valid_i,
  input logic                  in_stall_o,
  input logic                  out_valid_o,
  input logic                  out_stall_i,
  input logic [CHAR_WIDTH-1:0] digit_char_o,
  input logic                  last_digit_o
);

  logic [CHAR_WIDTH:0] out_word;
  logic                out_wait;
  logic                in_take;
  logic                last_take;
  logic                char_ok;

  // Handshake terms
  assign out_word  = {last_digit_o, digit_char_o};
  assign out_wait  = out_valid_o && out_stall_i;
  assign in_take   = in_valid_i && !in_stall_o;
  assign last_take = out_valid_o && !out_stall_i && last_digit_o;

  // Characters are 0-9 or A-Z
  assign char_ok = ((digit_char_o >= 7'd48) && (digit_char_o <= 7'd57)) ||
                   ((digit_char_o >= 7'd65) && (digit_char_o <= 7'd90));

  // A stalled result holds
  `NBC_ASSERT_NEXT(a_out_hold, out_wait, out_valid_o && $stable(out_word), "stalled result changed")

  // Busy right after an input transfer
  `NBC_ASSERT_NEXT(a_busy_after_accept, in_take, in_stall_o, "input taken while converting")

  // No new input while digits are being sent
  `NBC_ASSERT_NOW(a_stall_while_sending, out_valid_o, in_stall_o, "input open during output")

  // Characters presented while valid are always 0-9 or A-Z
  `NBC_ASSERT_NOW(a_char_range, out_valid_o, char_ok, "digit character out of range")

  // Run ends after the last digit
  `NBC_ASSERT_NEXT(a_end_of_run, last_take, !out_valid_o, "output after last digit")

endmodule

bind negative_base_converter_unit nbc_checker u_nbc_checker (.*);
